### rtl/self_calibrating_moisture_sensor_unit_assert.svh
// Assertion macros for the moisture sensor unit.
`ifndef SELF_CALIBRATING_MOISTURE_SENSOR_UNIT_ASSERT_SVH
`define SELF_CALIBRATING_MOISTURE_SENSOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checked outside reset.
`define SCMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define SCMS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCMS_ASSERT(label, prop, msg)
`define SCMS_ASSERT_RST(label, prop, msg)
`endif

`endif

### rtl/scms_pkg.sv
// Shared types and constants for the moisture sensor unit.
package scms_pkg;

    localparam int ADC_W        = 12;
    localparam int PCT_W        = 7;
    localparam int TICK_W       = 24;
    localparam int MARGIN_W     = 12;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int SPR_DEFAULT  = 5;
    localparam int SPR_MAX      = 7;
    localparam int SUM_MAX_W    = ADC_W + $clog2(SPR_MAX + 1);
    localparam int PCT_SCALE    = 100;
    localparam int DIV_W        = ADC_W + PCT_W;
    localparam int Q_DEPTH      = 2;

    localparam logic [ADC_W-1:0]  ADC_FULL = {ADC_W{1'b1}};
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [PCT_W-1:0]    THRESHOLD_RST = 7'd60;
    localparam logic [TICK_W-1:0]   SETTLE_RST    = 24'd300000;
    localparam logic [MARGIN_W-1:0] WET_MARGIN_RST = 12'd50;
    localparam logic [MARGIN_W-1:0] DRY_MARGIN_RST = 12'd900;
    localparam logic [ADC_W-1:0]    CEILING_RST   = 12'd3600;

    // Input action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_SETTLE     = 3'd1,
        CFG_WET_MARGIN = 3'd2,
        CFG_DRY_MARGIN = 3'd3,
        CFG_CEILING    = 3'd4
    } cfg_idx_e;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_READING = 1'b1
    } op_e;

    typedef struct packed {
        logic [PCT_W-1:0]    threshold_pct;
        logic [TICK_W-1:0]   settle_ticks;
        logic [MARGIN_W-1:0] wet_margin;
        logic [MARGIN_W-1:0] dry_margin;
        logic [ADC_W-1:0]    dry_ceiling;
    } cfg_t;

    typedef struct packed {
        op_e                  op;
        logic [SUM_MAX_W-1:0] sum;
    } q_entry_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [ADC_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/scms_div.sv
// Restoring serial divider, one quotient bit per cycle.
module scms_div (
    input  logic             clk,
    input  logic             rst_n,
    input  scms_pkg::div_req_t req,
    output scms_pkg::div_rsp_t rsp
);
    import scms_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADC_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [ADC_W-1:0]  dvs_reg, dvs_next;
    logic [ADC_W:0]    trial;
    logic [ADC_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[ADC_W-1:0] : trial[ADC_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### rtl/scms_queue.sv
// Short queue between front and back.
module scms_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  scms_pkg::q_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output scms_pkg::q_entry_t pop_data,
    output logic               not_empty
);
    import scms_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    q_entry_t          mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = count_reg == CNT_W'(Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/scms_front.sv
// Front end: takes items, sums samples, queues ticks and completed sums.
module scms_front #(
    parameter int SAMPLES_PER_READING = scms_pkg::SPR_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [scms_pkg::ADC_W-1:0] adc_sample,
    input  logic                       q_full,
    output logic                       push,
    output scms_pkg::q_entry_t         push_data
);
    import scms_pkg::*;

    localparam int SUM_W = ADC_W + $clog2(SAMPLES_PER_READING);
    localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);

    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] total;
    logic             take;
    logic             last;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign total    = sum_reg + SUM_W'(adc_sample);
    assign last     = count_reg == CNT_W'(SAMPLES_PER_READING - 1);

    always_comb
    begin
        push          = 1'b0;
        push_data.op  = OP_TICK;
        push_data.sum = SUM_MAX_W'(total);
        if (take)
        begin
            if (action == ACT_TICK)
                push = 1'b1;
            else if (last)
            begin
                push         = 1'b1;
                push_data.op = OP_READING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (take && action == ACT_SAMPLE)
        begin
            if (last)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= total;
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

endmodule

### rtl/scms_back.sv
// Back end: tick counter, averaging, calibration and percentage mapping.
module scms_back #(
    parameter int SAMPLES_PER_READING = scms_pkg::SPR_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  scms_pkg::cfg_t             cfg,
    input  logic                       q_valid,
    input  scms_pkg::q_entry_t         q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [scms_pkg::PCT_W-1:0] moisture_percent,
    output logic [scms_pkg::ADC_W-1:0] raw_average,
    output logic                       settling,
    output logic [scms_pkg::ADC_W-1:0] wet_point,
    output logic [scms_pkg::ADC_W-1:0] dry_point,
    output logic                       calibration_done
);
    import scms_pkg::*;

    // average by reciprocal multiply, exact for every sum below 2**SUM_MAX_W
    localparam int RECIP_SH = SUM_MAX_W + $clog2(SPR_MAX + 1);
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SUM_MAX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SH) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT,
        S_MAP,
        S_PCT,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic [ADC_W-1:0]   prev_reg;
    logic [ADC_W-1:0]   lowest_reg;
    logic               settling_reg;
    logic [TICK_W-1:0]  counter_reg;
    logic [ADC_W-1:0]   wet_reg;
    logic [ADC_W-1:0]   dry_reg;
    logic [ADC_W-1:0]   reading_reg;
    logic               water_reg;
    logic               cal_reg;
    logic [PCT_W-1:0]   pct_reg;
    div_req_t           div_req_reg;
    div_rsp_t           div_rsp;

    // averaging
    logic [PROD_W-1:0]  avg_prod;
    // watering compare
    logic [DIV_W-1:0]   prod_now;
    logic [DIV_W-1:0]   prod_prev;
    // calibration update
    logic               settle_new;
    logic [ADC_W-1:0]   lowest_new;
    logic [TICK_W-1:0]  counter_new;
    logic               commit;
    logic [MARGIN_W:0]  wet_limit;
    logic [ADC_W-1:0]   wet_cand;
    logic [ADC_W:0]     dry_sum;
    logic [ADC_W-1:0]   dry_cand;
    // mapping
    logic [ADC_W-1:0]   x_lo;
    logic [ADC_W-1:0]   x_clamp;
    logic [DIV_W-1:0]   numer;

    scms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    assign avg_prod  = PROD_W'(q_data.sum) * PROD_W'(RECIP);

    assign prod_now  = DIV_W'(reading_reg) * DIV_W'(PCT_SCALE);
    assign prod_prev = DIV_W'(prev_reg) * DIV_W'(cfg.threshold_pct);

    always_comb
    begin
        settle_new  = settling_reg;
        lowest_new  = lowest_reg;
        counter_new = counter_reg;
        if (water_reg)
        begin
            settle_new  = 1'b1;
            lowest_new  = reading_reg;
            counter_new = '0;
        end
        else if (settling_reg && reading_reg < lowest_reg)
            lowest_new = reading_reg;
    end

    assign commit    = settle_new && (counter_new >= cfg.settle_ticks);
    assign wet_limit = {1'b0, cfg.wet_margin} + (MARGIN_W + 1)'(1);
    assign wet_cand  = ({1'b0, lowest_new} > wet_limit)
                       ? lowest_new - cfg.wet_margin : ADC_W'(1);
    assign dry_sum   = {1'b0, reading_reg} + {1'b0, cfg.dry_margin};
    assign dry_cand  = (dry_sum < {1'b0, cfg.dry_ceiling})
                       ? dry_sum[ADC_W-1:0] : cfg.dry_ceiling;

    // raise to the wet point, then lower to the dry point
    assign x_lo    = (reading_reg < wet_reg) ? wet_reg : reading_reg;
    assign x_clamp = (x_lo > dry_reg) ? dry_reg : x_lo;
    assign numer   = DIV_W'(dry_reg - x_clamp) * DIV_W'(PCT_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            prev_reg         <= '0;
            lowest_reg       <= ADC_FULL;
            settling_reg     <= 1'b0;
            counter_reg      <= '0;
            wet_reg          <= ADC_W'(1);
            dry_reg          <= ADC_FULL;
            reading_reg      <= '0;
            water_reg        <= 1'b0;
            cal_reg          <= 1'b0;
            pct_reg          <= '0;
            div_req_reg      <= '0;
            out_valid        <= 1'b0;
            moisture_percent <= '0;
            raw_average      <= '0;
            settling         <= 1'b0;
            wet_point        <= '0;
            dry_point        <= '0;
            calibration_done <= 1'b0;
        end
        else
        begin
            div_req_reg.start <= (state_reg == S_MAP) && (wet_reg < dry_reg);
            if (out_valid && out_ready && state_reg != S_OUT)
                out_valid <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_data.op == OP_TICK)
                        begin
                            if (counter_reg != TICK_MAX)
                                counter_reg <= counter_reg + TICK_W'(1);
                        end
                        else
                        begin
                            reading_reg <= avg_prod[RECIP_SH +: ADC_W];
                            state_reg   <= S_EVAL;
                        end
                    end
                end
                S_EVAL:
                begin
                    water_reg <= prod_now < prod_prev;
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    prev_reg     <= reading_reg;
                    lowest_reg   <= lowest_new;
                    counter_reg  <= counter_new;
                    settling_reg <= settle_new && !commit;
                    cal_reg      <= commit;
                    if (commit)
                    begin
                        wet_reg <= wet_cand;
                        dry_reg <= dry_cand;
                    end
                    state_reg <= S_MAP;
                end
                S_MAP:
                begin
                    if (wet_reg < dry_reg)
                    begin
                        div_req_reg.dividend <= numer;
                        div_req_reg.divisor  <= dry_reg - wet_reg;
                        state_reg            <= S_PCT;
                    end
                    else
                    begin
                        pct_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_PCT:
                begin
                    if (div_rsp.done)
                    begin
                        pct_reg   <= div_rsp.quotient[PCT_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_valid        <= 1'b1;
                        moisture_percent <= pct_reg;
                        raw_average      <= reading_reg;
                        settling         <= settling_reg;
                        wet_point        <= wet_reg;
                        dry_point        <= dry_reg;
                        calibration_done <= cal_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/self_calibrating_moisture_sensor_unit.sv
// Top level of the self-calibrating soil moisture sensor unit.
//
//  Channel   Signals                                   Direction
//  input     in_valid/in_ready, action, adc_sample     in
//  result    out_valid/out_ready, moisture_percent,    out
//            raw_average, settling, wet_point,
//            dry_point, calibration_done
//  config    cfg_write, cfg_index, cfg_data            in (write only)
//
//  A tick is taken by the back end in its idle state; a sample that does not complete
//  a reading is absorbed by the front end in its transfer cycle. A completed reading
//  holds the back end through a reciprocal multiply for the average, then compare,
//  commit and map states, and the serial divider (one quotient bit per cycle) for the
//  percentage; the divider is skipped when the points leave no span to divide by.
//  Asynchronous active-low reset; no clearing pass, the unit is ready straight away.
//  A two-entry queue lets the front keep taking transfers while the back works, until
//  the queue fills; the output register holds a result while out_ready is low.
`include "self_calibrating_moisture_sensor_unit_assert.svh"

module self_calibrating_moisture_sensor_unit #(
    parameter int SAMPLES_PER_READING = scms_pkg::SPR_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [scms_pkg::ADC_W-1:0]      adc_sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [scms_pkg::PCT_W-1:0]      moisture_percent,
    output logic [scms_pkg::ADC_W-1:0]      raw_average,
    output logic                            settling,
    output logic [scms_pkg::ADC_W-1:0]      wet_point,
    output logic [scms_pkg::ADC_W-1:0]      dry_point,
    output logic                            calibration_done,
    input  logic                            cfg_write,
    input  logic [scms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import scms_pkg::*;

    cfg_t     cfg_reg;
    logic     q_full;
    logic     q_push;
    q_entry_t q_push_data;
    logic     q_pop;
    q_entry_t q_pop_data;
    logic     q_not_empty;

    // Configuration registers: upper data bits dropped, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_pct <= THRESHOLD_RST;
            cfg_reg.settle_ticks  <= SETTLE_RST;
            cfg_reg.wet_margin    <= WET_MARGIN_RST;
            cfg_reg.dry_margin    <= DRY_MARGIN_RST;
            cfg_reg.dry_ceiling   <= CEILING_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_THRESHOLD:  cfg_reg.threshold_pct <= cfg_data[PCT_W-1:0];
                CFG_SETTLE:     cfg_reg.settle_ticks  <= cfg_data[TICK_W-1:0];
                CFG_WET_MARGIN: cfg_reg.wet_margin    <= cfg_data[MARGIN_W-1:0];
                CFG_DRY_MARGIN: cfg_reg.dry_margin    <= cfg_data[MARGIN_W-1:0];
                CFG_CEILING:    cfg_reg.dry_ceiling   <= cfg_data[ADC_W-1:0];
                default:        ;
            endcase
        end
    end

    // Front: accepts transfers, builds sums
    scms_front #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .adc_sample (adc_sample),
        .q_full     (q_full),
        .push       (q_push),
        .push_data  (q_push_data)
    );

    scms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    // Back: counter, calibration, mapping, output register
    scms_back #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_valid          (q_not_empty),
        .q_data           (q_pop_data),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .moisture_percent (moisture_percent),
        .raw_average      (raw_average),
        .settling         (settling),
        .wet_point        (wet_point),
        .dry_point        (dry_point),
        .calibration_done (calibration_done)
    );

    // Checks
    `SCMS_ASSERT(a_pct_range, out_valid |-> (moisture_percent <= 7'd100), "percent above 100")
    `SCMS_ASSERT(a_commit_ends_settle, out_valid |-> !(settling && calibration_done), "settling after commit")
    `SCMS_ASSERT(a_flat_points_zero, (out_valid && (wet_point >= dry_point)) |-> (moisture_percent == 7'd0), "non-zero percent with inverted points")
    `SCMS_ASSERT_RST(a_reset_no_result, !rst_n |=> !out_valid, "result shown right after reset")

endmodule

### bench/self_calibrating_moisture_sensor_unit_tb.sv
// Self-checking testbench for the self-calibrating soil moisture sensor unit.
module self_calibrating_moisture_sensor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scms_pkg::*;

    localparam int SPR          = SPR_DEFAULT;
    localparam int RESET_CYCLES = 10;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 135;
    // This covers a reading still in the back end and any ticks still queued.
    localparam int DRAIN_CYCLES = 200;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int THR_TOP      = (1 << PCT_W) - 1;
    localparam int SPARE_IDX_LO = int'(CFG_CEILING) + 1;
    localparam int SPARE_IDX_HI = (1 << CFG_IDX_W) - 1;
    localparam int TICK_HINT    = 40;

    typedef struct packed {
        logic             act;
        logic [ADC_W-1:0] smp;
    } sensor_item_t;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [ADC_W-1:0] avg;
        logic             settling;
        logic [ADC_W-1:0] wet;
        logic [ADC_W-1:0] dry;
        logic             done;
    } reading_t;

    // Receiver behaviour, cycled through as the run goes on
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_STALLS
    } rx_mode_e;

    // ---------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ---------------------------------------------------------------
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  action     = ACT_SAMPLE;
    logic [ADC_W-1:0]      adc_sample = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [PCT_W-1:0]      moisture_percent;
    logic [ADC_W-1:0]      raw_average;
    logic                  settling;
    logic [ADC_W-1:0]      wet_point;
    logic [ADC_W-1:0]      dry_point;
    logic                  calibration_done;
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    always #10 clk = ~clk;

    self_calibrating_moisture_sensor_unit #(
        .SAMPLES_PER_READING(SPR)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .adc_sample       (adc_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .moisture_percent (moisture_percent),
        .raw_average      (raw_average),
        .settling         (settling),
        .wet_point        (wet_point),
        .dry_point        (dry_point),
        .calibration_done (calibration_done),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor state: own copy of the registers and calibration state
    // ---------------------------------------------------------------
    logic [PCT_W-1:0]     thr_pct    = THRESHOLD_RST;
    logic [TICK_W-1:0]    settle_lim = SETTLE_RST;
    logic [MARGIN_W-1:0]  wet_marg   = WET_MARGIN_RST;
    logic [MARGIN_W-1:0]  dry_marg   = DRY_MARGIN_RST;
    logic [ADC_W-1:0]     dry_ceil   = CEILING_RST;

    logic [SUM_MAX_W-1:0] soil_sum       = '0;
    logic [2:0]           soil_count     = '0;
    logic [ADC_W-1:0]     last_reading   = '0;
    logic [ADC_W-1:0]     min_reading    = ADC_FULL;
    logic                 settle_pending = 1'b0;
    logic [TICK_W-1:0]    tick_count     = '0;
    logic [ADC_W-1:0]     wet_cal        = ADC_W'(1);
    logic [ADC_W-1:0]     dry_cal        = ADC_FULL;

    sensor_item_t sensor_q[$];      // items waiting for the driver
    reading_t     readings_due[$];  // predicted results, oldest first

    int fail_count    = 0;
    int items_sent    = 0;
    int readings_seen = 0;
    int commits_seen  = 0;
    int settings_done = 0;
    int phase_items   = 0;

    // Register write as the block sees it: upper bits beyond the width drop away,
    // indexes past the last register do nothing.
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_THRESHOLD:  thr_pct    = val[PCT_W-1:0];
            CFG_SETTLE:     settle_lim = val[TICK_W-1:0];
            CFG_WET_MARGIN: wet_marg   = val[MARGIN_W-1:0];
            CFG_DRY_MARGIN: dry_marg   = val[MARGIN_W-1:0];
            CFG_CEILING:    dry_ceil   = val[ADC_W-1:0];
            default: ;
        endcase
    endfunction

    // Clamp into the wet..dry window, then scale inversely to 0..100.
    function automatic int moisture_of(int rd);
        int x;
        int p;
        x = rd;
        if (x < int'(wet_cal)) x = int'(wet_cal);
        if (x > int'(dry_cal)) x = int'(dry_cal);
        if (wet_cal == dry_cal) return 0;
        // SystemVerilog int division truncates towards zero, as required
        p = ((x - int'(dry_cal)) * PCT_SCALE) / (int'(wet_cal) - int'(dry_cal));
        if (p < 0) p = 0;
        if (p > PCT_SCALE) p = PCT_SCALE;
        return p;
    endfunction

    // Advance the predictor by one accepted transfer; a completed reading
    // queues the result it must produce.
    function automatic void compute_reading(logic act, logic [ADC_W-1:0] smp);
        reading_t r;
        int       rd;
        int       hi;
        if (act == ACT_TICK) begin
            if (tick_count != TICK_MAX) tick_count = tick_count + 1'b1;
            return;
        end
        soil_sum   = soil_sum + smp;
        soil_count = soil_count + 1'b1;
        if (int'(soil_count) < SPR) return;

        rd         = int'(soil_sum) / SPR;
        soil_sum   = '0;
        soil_count = '0;

        // Watering: sharp drop against the previous reading restarts settling
        if (rd * PCT_SCALE < int'(last_reading) * int'(thr_pct)) begin
            settle_pending = 1'b1;
            tick_count     = '0;
            min_reading    = ADC_W'(rd);
        end else if (settle_pending && rd < int'(min_reading)) begin
            min_reading = ADC_W'(rd);
        end
        last_reading = ADC_W'(rd);

        r.done = 1'b0;
        if (settle_pending && tick_count >= settle_lim) begin
            hi      = rd + int'(dry_marg);
            wet_cal = ADC_W'((int'(min_reading) > int'(wet_marg) + 1)
                             ? int'(min_reading) - int'(wet_marg) : 1);
            dry_cal = ADC_W'((hi < int'(dry_ceil)) ? hi : int'(dry_ceil));
            settle_pending = 1'b0;
            r.done = 1'b1;
        end

        r.pct      = PCT_W'(moisture_of(rd));
        r.avg      = ADC_W'(rd);
        r.settling = settle_pending;
        r.wet      = wet_cal;
        r.dry      = dry_cal;
        readings_due.push_back(r);
    endfunction

    function automatic void check_field(string field, logic [ADC_W-1:0] exp_v,
                                        logic [ADC_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", field, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: bursts of transfers with random gaps between them
    // ---------------------------------------------------------------
    sensor_item_t drv_item;
    int           burst_left = 0;
    int           gap_left   = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                compute_reading(action, adc_sample);
                items_sent++;
            end
            // Payload only moves once the current transfer has gone
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (sensor_q.size() != 0) begin
                    drv_item   = sensor_q.pop_front();
                    in_valid   <= 1'b1;
                    action     <= drv_item.act;
                    adc_sample <= drv_item.smp;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        // a quarter of bursts run straight into the next
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compares each result transfer and drives out_ready
    // ---------------------------------------------------------------
    reading_t mon_due;
    rx_mode_e ready_mode = RX_OPEN;
    int       mon_cycles = 0;
    int       stall_left = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (readings_due.size() == 0) begin
                    $error("result transfer with no reading pending: raw_average %0d",
                           raw_average);
                    fail_count++;
                end else begin
                    mon_due = readings_due.pop_front();
                    check_field("moisture_percent", ADC_W'(mon_due.pct),
                                ADC_W'(moisture_percent));
                    check_field("raw_average", mon_due.avg, raw_average);
                    check_field("settling", ADC_W'(mon_due.settling), ADC_W'(settling));
                    check_field("wet_point", mon_due.wet, wet_point);
                    check_field("dry_point", mon_due.dry, dry_point);
                    check_field("calibration_done", ADC_W'(mon_due.done),
                                ADC_W'(calibration_done));
                    readings_seen++;
                    if (mon_due.done) commits_seen++;
                end
            end

            mon_cycles++;
            ready_mode = rx_mode_e'((mon_cycles / 300) % 3);
            if (stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    RX_OPEN:  out_ready <= 1'b1;
                    RX_COIN:  out_ready <= ($urandom_range(0, 1) == 1);
                    default:
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(1, 20);
                            out_ready  <= 1'b0;
                        end else begin
                            out_ready  <= 1'b1;
                        end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic void push_item(logic act, logic [ADC_W-1:0] smp);
        sensor_item_t it;
        it.act = act;
        it.smp = smp;
        sensor_q.push_back(it);
        phase_items++;
    endfunction

    // Ticks carry random sample bits, which the block must ignore
    function automatic void push_ticks(int n);
        repeat (n) push_item(ACT_TICK, ADC_W'($urandom_range(0, int'(ADC_FULL))));
    endfunction

    // One reading's worth of samples scattered round a level, with stray ticks
    function automatic void push_reading(int level, int spread);
        int s;
        for (int i = 0; i < SPR; i++) begin
            s = level - spread + int'($urandom_range(0, 2 * spread));
            if (s < 0) s = 0;
            if (s > int'(ADC_FULL)) s = int'(ADC_FULL);
            push_item(ACT_SAMPLE, ADC_W'(s));
            if ($urandom_range(0, 7) == 0) push_ticks(1);
        end
    endfunction

    // Dry soil, a watering drop, then a few settling readings with ticks between
    function automatic void push_episode(int tick_hint);
        int dry_lvl;
        int wet_lvl;
        int n;
        dry_lvl = $urandom_range(800, int'(ADC_FULL));
        repeat ($urandom_range(1, 3)) push_reading(dry_lvl, $urandom_range(0, 40));
        wet_lvl = dry_lvl * int'($urandom_range(5, 58)) / PCT_SCALE;
        push_reading(wet_lvl, $urandom_range(0, 10));
        n = $urandom_range(1, 4);
        repeat (n) begin
            push_ticks($urandom_range(0, tick_hint / n + 3));
            wet_lvl = wet_lvl - 30 + int'($urandom_range(0, 60));
            if (wet_lvl < 0) wet_lvl = 0;
            if (wet_lvl > int'(ADC_FULL)) wet_lvl = int'(ADC_FULL);
            push_reading(wet_lvl, $urandom_range(0, 20));
        end
    endfunction

    // Unstructured items: any action, any sample
    function automatic void push_noise();
        repeat ($urandom_range(1, 12))
            push_item(1'($urandom_range(0, 1)), ADC_W'($urandom_range(0, int'(ADC_FULL))));
    endfunction

    function automatic void push_directed();
        // full scale: maps to dry, no drop against a zero previous reading
        repeat (SPR) push_item(ACT_SAMPLE, ADC_FULL);
        push_item(ACT_TICK, ADC_FULL);
        // all zero: watering, and the reading is raised to the wet point
        repeat (SPR) push_item(ACT_SAMPLE, '0);
        // alternating extremes with a tick mid-reading
        push_item(ACT_SAMPLE, ADC_FULL);
        push_item(ACT_TICK, '0);
        push_item(ACT_SAMPLE, '0);
        push_item(ACT_SAMPLE, ADC_FULL);
        push_item(ACT_SAMPLE, '0);
        push_item(ACT_SAMPLE, ADC_FULL);
        // alternating bit patterns
        push_item(ACT_SAMPLE, 12'hAAA);
        push_item(ACT_SAMPLE, 12'h555);
        push_item(ACT_SAMPLE, 12'hAAA);
        push_item(ACT_SAMPLE, 12'h555);
        push_item(ACT_SAMPLE, 12'h001);
    endfunction

    function automatic void fill_phase(int budget);
        int tick_hint;
        tick_hint = (settle_lim > TICK_HINT) ? TICK_HINT : int'(settle_lim);
        while (phase_items < budget) begin
            if ($urandom_range(0, 4) == 0) push_noise();
            else push_episode(tick_hint);
        end
    endfunction

    // ---------------------------------------------------------------
    // Register programming, only while the unit is idle
    // ---------------------------------------------------------------
    // Keeps the value in the register's own bits and fills the rest at random
    function automatic logic [CFG_DATA_W-1:0] with_junk(int v, int w);
        int mask;
        mask = (1 << w) - 1;
        return CFG_DATA_W'(($urandom & ~mask) | (v & mask));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        apply_reg(idx, val);
    endtask

    task automatic program_unit(int thr, int settle, int wm, int dm, int ceil_v);
        write_reg(CFG_THRESHOLD, with_junk(thr, PCT_W));
        write_reg(CFG_SETTLE, CFG_DATA_W'(settle));
        write_reg(CFG_WET_MARGIN, with_junk(wm, MARGIN_W));
        write_reg(CFG_DRY_MARGIN, with_junk(dm, MARGIN_W));
        write_reg(CFG_CEILING, with_junk(ceil_v, ADC_W));
        // an index past the register file must change nothing
        write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)),
                  CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_done++;
    endtask

    // Sampled on the falling edge so driver and monitor updates have settled
    task automatic wait_idle();
        while (sensor_q.size() != 0 || in_valid || readings_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Sequence: reset, directed items, then phases of settings
    // ---------------------------------------------------------------
    initial begin
        int full;
        full = int'(ADC_FULL);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                wait_idle();
                case (ph)
                    // threshold beyond 100, commit on the detecting reading, no margins
                    1: program_unit(THR_TOP, 0, 0, 0, full);
                    // never waters; longest settle time; widest margins
                    2: program_unit(0, int'(TICK_MAX), full, full, full);
                    // ceiling of zero: dry point below wet, inverted window
                    3: program_unit(PCT_SCALE, 0, full, full, 0);
                    // ceiling of one: wet and dry points coincide
                    4: program_unit(THRESHOLD_RST, 0, full, 0, 1);
                    5: program_unit(THRESHOLD_RST, 1, WET_MARGIN_RST, DRY_MARGIN_RST,
                                    CEILING_RST);
                    default:
                        program_unit(
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, THR_TOP)
                                                        : $urandom_range(30, 95),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(TICK_MAX))
                                                        : $urandom_range(0, TICK_HINT),
                            ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200)
                                                        : $urandom_range(0, full),
                            ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1200)
                                                        : $urandom_range(0, full),
                            ($urandom_range(0, 1) == 0) ? $urandom_range(2000, full)
                                                        : $urandom_range(0, full));
                endcase
            end
            phase_items = 0;
            if (ph == 0) push_directed();
            fill_phase(PHASE_ITEMS);
        end

        wait_idle();
        $display("Covered %0d transfers over %0d register settings after reset defaults:",
                 items_sent, settings_done);
        $display("  %0d readings checked, %0d of them committing a new calibration.",
                 readings_seen, commits_seen);
        if (fail_count == 0 && readings_due.size() == 0) begin
            $display("PASS self_calibrating_moisture_sensor_unit");
        end else begin
            $display("FAIL self_calibrating_moisture_sensor_unit");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL self_calibrating_moisture_sensor_unit");
        $finish;
    end

endmodule
